// File: sv/fccw_pkg.sv
// Package for the FAT12 cluster chain walker.
// Holds table sizing, command and status codes, and the structs shared between the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fccw_pkg;

    // Allocation table size in bytes, split across an even and an odd bank
    localparam int TABLE_BYTES = 8192;
    localparam int TBL_AW      = $clog2(TABLE_BYTES);
    localparam int BANK_AW     = TBL_AW - 1;
    localparam int BANK_DEPTH  = (TABLE_BYTES + 1) / 2;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 13;
    localparam int BYTE_W    = 8;
    localparam int CLUSTER_W = 12;
    localparam int SECTOR_W  = 16;
    localparam int STATUS_W  = 2;

    // Stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 3;

    localparam logic [CLUSTER_W-1:0] END_MARK  = 12'hFF8;
    localparam logic [SECTOR_W-1:0]  BASE_RESET = 16'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_START   = 2'd1,
        CMD_ADVANCE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CONTINUE = 2'd0,
        STAT_END      = 2'd1,
        STAT_CORRUPT  = 2'd2
    } t_status;

    // Table access request from the controller to the byte store
    typedef struct packed {
        logic                 wr_en;
        logic [INDEX_W-1:0]   wr_index;
        logic [BYTE_W-1:0]    wr_data;
        logic                 rd_en;
        logic [CLUSTER_W-1:0] rd_cluster;
    } t_tbl_req;

    // One result item
    typedef struct packed {
        logic [SECTOR_W-1:0]  data_sector;
        logic [CLUSTER_W-1:0] next_cluster;
        logic [STATUS_W-1:0]  chain_status;
        logic                 end_flag;
    } t_result;

endpackage

`default_nettype wire

// File: sv/fccw_table_store.sv
// Allocation table byte store: two synchronous banks (even / odd byte offsets).
// Reads the two bytes of a packed 12-bit entry in one access. Uses fccw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fccw_table_store (
    input  wire logic              i_clk,
    input  wire fccw_pkg::t_tbl_req i_req,
    output logic [15:0]            o_pair
);
    import fccw_pkg::*;

    logic [BYTE_W-1:0] r_even [0:BANK_DEPTH-1];
    logic [BYTE_W-1:0] r_odd  [0:BANK_DEPTH-1];

    logic [TBL_AW-1:0]  wr_addr;
    logic               wr_ok;
    logic [TBL_AW-1:0]  rd_at;
    logic [BANK_AW-1:0] even_addr;
    logic [BANK_AW-1:0] odd_addr;
    logic               lo_ok;
    logic               hi_ok;

    logic [BYTE_W-1:0]  r_even_q;
    logic [BYTE_W-1:0]  r_odd_q;
    logic               r_swap;
    logic               r_lo_ok;
    logic               r_hi_ok;
    logic [BYTE_W-1:0]  lo_byte;
    logic [BYTE_W-1:0]  hi_byte;

    // Write address and range check
    always_comb begin
        wr_addr = TBL_AW'(i_req.wr_index);
        wr_ok   = (32'(i_req.wr_index) < TABLE_BYTES);
    end

    // Entry offset is cluster + cluster/2; the pair straddles both banks
    always_comb begin
        rd_at     = TBL_AW'(i_req.rd_cluster) + TBL_AW'(i_req.rd_cluster >> 1);
        odd_addr  = rd_at[TBL_AW-1:1];
        even_addr = rd_at[0] ? rd_at[TBL_AW-1:1] + BANK_AW'(1) : rd_at[TBL_AW-1:1];
        lo_ok     = (32'(rd_at) < TABLE_BYTES);
        hi_ok     = (32'(rd_at) + 32'd1 < TABLE_BYTES);
    end

    // Even bank
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && wr_ok && !wr_addr[0]) begin
            r_even[wr_addr[TBL_AW-1:1]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_even_q <= r_even[even_addr];
        end
    end

    // Odd bank
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && wr_ok && wr_addr[0]) begin
            r_odd[wr_addr[TBL_AW-1:1]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_odd_q <= r_odd[odd_addr];
        end
    end

    // Read side tags travel with the data
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_swap  <= rd_at[0];
            r_lo_ok <= lo_ok;
            r_hi_ok <= hi_ok;
        end
    end

    // Put the bytes back in offset order; bytes past the table read as zero
    always_comb begin
        lo_byte = r_swap ? r_odd_q : r_even_q;
        hi_byte = r_swap ? r_even_q : r_odd_q;
        o_pair  = {(r_hi_ok ? hi_byte : '0), (r_lo_ok ? lo_byte : '0)};
    end

endmodule

`default_nettype wire

// File: sv/fccw_out_queue.sv
// Two-entry result queue in front of the master stream port.
// Lets the controller finish an item while an earlier result waits. Uses fccw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fccw_out_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire fccw_pkg::t_result i_result,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output fccw_pkg::t_result      o_result
);
    import fccw_pkg::*;

    t_result    r_slot [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       pop;

    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_count != 2'd0);
    assign o_full   = (r_count == 2'd2);
    assign o_result = r_slot[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_result;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'd2))
        else $error("result pushed into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd3) && ((r_count == 2'd0) || (r_count == 2'd2) ||
        (r_wr_ptr != r_rd_ptr)))
        else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

// File: sv/fccw_chain_ctrl.sv
// Command sequencer: table writes, chain start, and the advance lookup.
// Holds the current cluster and end flag; drives fccw_table_store. Uses fccw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fccw_chain_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [fccw_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [fccw_pkg::INDEX_W-1:0]    i_table_index,
    input  wire logic [fccw_pkg::BYTE_W-1:0]     i_table_byte,
    input  wire logic [fccw_pkg::CLUSTER_W-1:0]  i_start_cluster,
    input  wire logic [fccw_pkg::SECTOR_W-1:0]   i_base,
    input  wire logic [15:0]                     i_pair,
    input  wire logic                            i_q_full,
    output fccw_pkg::t_tbl_req                   o_tbl_req,
    output logic                                 o_push,
    output fccw_pkg::t_result                    o_result
);
    import fccw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [CLUSTER_W-1:0] r_cluster;
    logic [CLUSTER_W-1:0] n_cluster;
    logic                 r_end;
    logic                 n_end;

    logic                 accept;
    logic [CLUSTER_W-1:0] entry;
    t_status              status;
    logic [SECTOR_W-1:0]  sector;

    assign o_ready = (r_state == ST_IDLE) && !i_q_full;
    assign accept  = i_valid && o_ready;

    // Table requests: writes land at acceptance, an advance reads the current entry
    always_comb begin
        o_tbl_req.wr_en      = accept && (i_cmd == CMD_WRITE);
        o_tbl_req.wr_index   = i_table_index;
        o_tbl_req.wr_data    = i_table_byte;
        o_tbl_req.rd_en      = accept && (i_cmd == CMD_ADVANCE);
        o_tbl_req.rd_cluster = r_cluster;
    end

    // Entry decode: odd clusters take the upper 12 bits of the pair
    always_comb begin
        entry  = r_cluster[0] ? i_pair[15:4] : i_pair[11:0];
        sector = i_base + SECTOR_W'(r_cluster) - SECTOR_W'(1);
        if (entry >= END_MARK) begin
            status = STAT_END;
        end else if (entry == '0) begin
            status = STAT_CORRUPT;
        end else begin
            status = STAT_CONTINUE;
        end
    end

    // Sequencer and chain state
    always_comb begin
        n_state   = r_state;
        n_cluster = r_cluster;
        n_end     = r_end;
        o_push    = 1'b0;
        o_result  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_ADVANCE: begin
                            n_state = ST_LOOKUP;
                        end
                        CMD_START: begin
                            n_cluster = i_start_cluster;
                            n_end     = 1'b0;
                            o_push    = 1'b1;
                        end
                        default: begin
                            o_push = 1'b1;
                        end
                    endcase
                    o_result.end_flag = n_end;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_IDLE;
                o_push  = 1'b1;
                if (status == STAT_CONTINUE) begin
                    n_cluster = entry;
                end else begin
                    n_end = 1'b1;
                end
                o_result.data_sector  = sector;
                o_result.next_cluster = entry;
                o_result.chain_status = status;
                o_result.end_flag     = n_end;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cluster <= '0;
            r_end     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cluster <= n_cluster;
            r_end     <= n_end;
        end
    end

    a_lookup_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP) |=> (r_state == ST_IDLE))
        else $error("lookup state held longer than one cycle");

    a_stop_holds_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP && status != STAT_CONTINUE) |=> ($stable(r_cluster) && r_end))
        else $error("chain stop moved the cluster or missed the end flag");

endmodule

`default_nettype wire

// File: sv/fat12_cluster_chain_walker.sv
// Top level of the FAT12 cluster chain walker.
// Instantiates fccw_chain_ctrl, fccw_table_store and fccw_out_queue; uses fccw_pkg.
//
//   channel   direction  payload
//   s_axis    in         tuser: cmd; tdata: table_index, table_byte, start_cluster
//   m_axis    out        tuser: chain_status, end_flag; tdata: data_sector, next_cluster
//   cfg       in         i_cfg_wdata: data_sector_base, written when i_cfg_we is high
//
// A table write, a chain start or an unused command completes as it is accepted; an
// advance also passes through ST_LOOKUP, as the banked table store registers its read
// data ahead of the entry decode.
// Reset clears the cluster, the end flag and the result queue and loads base 32;
// the table contents are undefined until written. No clearing pass is needed.
// Up to two results queue at the output; s_axis_tready drops in the lookup state
// of an advance and while both queue slots are held.
`timescale 1ns / 1ps
`default_nettype none

module fat12_cluster_chain_walker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [12:0] table_index, [20:13] table_byte, [32:21] start_cluster, [39:33] zero
    input  wire logic [fccw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] cmd
    input  wire logic [fccw_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [15:0] data_sector, [27:16] next_cluster, [31:28] zero
    output logic [fccw_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // [1:0] chain_status, [2] end_flag
    output logic [fccw_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,
    input  wire logic                                i_cfg_we,
    input  wire logic [fccw_pkg::SECTOR_W-1:0]       i_cfg_wdata
);
    import fccw_pkg::*;

    logic [SECTOR_W-1:0] r_base;
    t_tbl_req            tbl_req;
    logic [15:0]         pair;
    logic                push;
    t_result             push_result;
    t_result             out_result;
    logic                q_full;

    // Data sector base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    fccw_chain_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_cmd           (s_axis_tuser[CMD_W-1:0]),
        .i_table_index   (s_axis_tdata[12:0]),
        .i_table_byte    (s_axis_tdata[20:13]),
        .i_start_cluster (s_axis_tdata[32:21]),
        .i_base          (r_base),
        .i_pair          (pair),
        .i_q_full        (q_full),
        .o_tbl_req       (tbl_req),
        .o_push          (push),
        .o_result        (push_result)
    );

    fccw_table_store u_store (
        .i_clk  (i_clk),
        .i_req  (tbl_req),
        .o_pair (pair)
    );

    fccw_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (push_result),
        .o_full   (q_full),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    // Output packing
    assign m_axis_tdata = {4'b0, out_result.next_cluster, out_result.data_sector};
    assign m_axis_tuser = {out_result.end_flag, out_result.chain_status};

endmodule

`default_nettype wire

// File: tb/fat12_cluster_chain_walker_test.sv
// Self-checking testbench for fat12_cluster_chain_walker: table loads, chain starts and
// cluster advances are predicted in-bench and compared against the result stream.
// Depends on fccw_pkg and fat12_cluster_chain_walker.
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_test;
    import fccw_pkg::*;

    // cmd 3 is not decoded by the block; it only reports the end flag
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RUN_LIMIT_NS = 8000000;
    localparam int PHASE_REQS = 380;

    // One request on the input stream
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [INDEX_W-1:0]   idx;
        logic [BYTE_W-1:0]    val;
        logic [CLUSTER_W-1:0] clus;
    } t_walk_req;

    // Planned request; entry halves become byte writes when they are issued
    typedef struct packed {
        t_walk_req            rq;
        bit                   is_entry;
        bit                   hi;
        logic [CLUSTER_W-1:0] ent;
    } t_plan;

    typedef struct packed {
        bit                  is_cfg;
        logic [SECTOR_W-1:0] base;
        t_walk_req           rq;
        bit                  typed;
        t_result             want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    // [12:0] table_index, [20:13] table_byte, [32:21] start_cluster, [39:33] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] cmd
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] data_sector, [27:16] next_cluster, [31:28] zero
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    // [1:0] chain_status, [2] end_flag
    wire [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [SECTOR_W-1:0]    i_cfg_wdata = BASE_RESET;

    fat12_cluster_chain_walker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the walker state
    logic [BYTE_W-1:0]    tbl [0:TABLE_BYTES-1];
    bit                   tbl_set [0:TABLE_BYTES-1];
    logic [CLUSTER_W-1:0] cur_clus = '0;
    bit                   end_seen = 1'b0;
    logic [SECTOR_W-1:0]  sect_base = BASE_RESET;

    t_result   pending_results [$];
    t_plan     plan_q [$];
    t_dir_row  dir_rows [$];

    int n_reqs = 0, n_adv = 0, n_end = 0, n_corrupt = 0, n_bases = 0;
    int n_results = 0, n_bad = 0;
    int hold_left = 0, stall_left = 0;
    bit hold_done = 1'b0;
    logic [31:0] cyc = '0;

    wire calm = (cyc[8:7] == 2'b00);
    wire rx_holding = (hold_left != 0);

    always @(posedge i_clk) cyc <= cyc + 1;

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Predict one result and advance the shadow state
    function automatic t_result walk_step(input t_walk_req rq);
        t_result              r;
        logic [INDEX_W-1:0]   at;
        logic [15:0]          pair;
        logic [CLUSTER_W-1:0] ent;
        r = '0;
        case (rq.cmd)
            CMD_WRITE: begin
                if (rq.idx < TABLE_BYTES) begin
                    tbl[rq.idx] = rq.val;
                    tbl_set[rq.idx] = 1'b1;
                end
            end
            CMD_START: begin
                cur_clus = rq.clus;
                end_seen = 1'b0;
            end
            CMD_ADVANCE: begin
                n_adv++;
                at = INDEX_W'(cur_clus) + INDEX_W'(cur_clus >> 1);
                pair = {tbl[at + 1], tbl[at]};
                ent = cur_clus[0] ? pair[15:4] : pair[11:0];
                r.data_sector = sect_base + SECTOR_W'(cur_clus) - 16'd1;
                r.next_cluster = ent;
                if (ent >= END_MARK) begin
                    r.chain_status = STAT_END;
                    end_seen = 1'b1;
                    n_end++;
                end else if (ent == '0) begin
                    r.chain_status = STAT_CORRUPT;
                    end_seen = 1'b1;
                    n_corrupt++;
                end else begin
                    cur_clus = ent;
                end
            end
            default: ;
        endcase
        r.end_flag = end_seen;
        return r;
    endfunction

    function automatic t_walk_req rnd_req(input logic [CMD_W-1:0] cmd);
        t_walk_req rq;
        rq.cmd = cmd;
        rq.idx = INDEX_W'($urandom_range(0, TABLE_BYTES - 1));
        rq.val = BYTE_W'($urandom_range(0, 255));
        rq.clus = CLUSTER_W'($urandom_range(0, 4095));
        return rq;
    endfunction

    // Offer one request, wait for it to be taken, predict, then maybe idle
    task automatic send(input t_walk_req rq, input bit typed, input t_result want);
        t_result got;
        int      gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.cmd;
        s_axis_tdata  <= {{(IN_TDATA_W - 33){1'b0}}, rq.clus, rq.val, rq.idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = walk_step(rq);
        pending_results.push_back(typed ? want : got);
        n_reqs++;
        gap = rx_holding ? 0 : pick_gap(calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Base register is only written with the block drained
    task automatic set_base(input logic [SECTOR_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        sect_base = v;
        n_bases++;
    endtask

    // Either a well-formed chain (entries, start, walk) or a few loose requests
    task automatic build_plan();
        logic [CLUSTER_W-1:0] chain [0:5];
        logic [CLUSTER_W-1:0] c, tail;
        int    len, k, j;
        bit    dup;
        t_plan p;
        if ($urandom_range(0, 9) < 7) begin
            len = $urandom_range(1, 6);
            chain[0] = CLUSTER_W'($urandom_range(0, 4095));
            for (k = 1; k < len; k++) begin
                do begin
                    c = CLUSTER_W'($urandom_range(1, 12'hFF7));
                    dup = 1'b0;
                    for (j = 0; j < k; j++) if (chain[j] == c) dup = 1'b1;
                end while (dup);
                chain[k] = c;
            end
            case ($urandom_range(0, 3))
                0: tail = CLUSTER_W'($urandom_range(END_MARK, 12'hFFF));
                1: tail = '0;
                default: tail = (len > 1) ? chain[$urandom_range(1, len - 1)] : END_MARK;
            endcase
            for (k = 0; k < len; k++) begin
                p = '0;
                p.rq = rnd_req(CMD_WRITE);
                p.rq.clus = chain[k];
                p.is_entry = 1'b1;
                p.ent = (k < len - 1) ? chain[k + 1] : tail;
                p.hi = ($urandom_range(0, 1) != 0);
                plan_q.push_back(p);
                p.hi = !p.hi;
                plan_q.push_back(p);
            end
            p = '0;
            p.rq = rnd_req(CMD_START);
            p.rq.clus = chain[0];
            plan_q.push_back(p);
            repeat (len + $urandom_range(0, 3)) begin
                p.rq = rnd_req(CMD_ADVANCE);
                plan_q.push_back(p);
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                p = '0;
                p.rq = rnd_req(CMD_W'($urandom_range(0, 3)));
                plan_q.push_back(p);
            end
        end
    endtask

    // Next request; an advance onto unwritten table bytes becomes a byte write first
    task automatic next_req(output t_walk_req rq);
        t_plan               p;
        logic [INDEX_W-1:0]  at;
        logic [BYTE_W-1:0]   old;
        if (plan_q.size() == 0) build_plan();
        p = plan_q.pop_front();
        rq = p.rq;
        if (p.is_entry) begin
            at = INDEX_W'(p.rq.clus) + INDEX_W'(p.rq.clus >> 1);
            if (p.hi) at = at + 13'd1;
            old = tbl_set[at] ? tbl[at] : BYTE_W'($urandom_range(0, 255));
            rq.idx = at;
            if (p.rq.clus[0])
                rq.val = p.hi ? p.ent[11:4] : {p.ent[3:0], old[3:0]};
            else
                rq.val = p.hi ? {old[7:4], p.ent[11:8]} : p.ent[7:0];
        end else if (rq.cmd == CMD_ADVANCE) begin
            at = INDEX_W'(cur_clus) + INDEX_W'(cur_clus >> 1);
            if (!tbl_set[at] || !tbl_set[at + 1]) begin
                plan_q.push_front(p);
                rq.cmd = CMD_WRITE;
                rq.idx = tbl_set[at] ? at + 13'd1 : at;
                rq.val = BYTE_W'($urandom_range(0, 255));
            end
        end
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                           input logic [BYTE_W-1:0] val, input logic [CLUSTER_W-1:0] clus);
        t_dir_row d;
        d = '0;
        d.rq = '{cmd: cmd, idx: idx, val: val, clus: clus};
        dir_rows.push_back(d);
    endtask

    task automatic add_row_x(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val, input logic [CLUSTER_W-1:0] clus,
                             input logic [SECTOR_W-1:0] sector,
                             input logic [CLUSTER_W-1:0] entry,
                             input t_status status, input bit endf);
        t_dir_row d;
        d = '0;
        d.rq = '{cmd: cmd, idx: idx, val: val, clus: clus};
        d.typed = 1'b1;
        d.want.data_sector = sector;
        d.want.next_cluster = entry;
        d.want.chain_status = status;
        d.want.end_flag = endf;
        dir_rows.push_back(d);
    endtask

    task automatic add_cfg(input logic [SECTOR_W-1:0] v);
        t_dir_row d;
        d = '0;
        d.is_cfg = 1'b1;
        d.base = v;
        dir_rows.push_back(d);
    endtask

    // Stimulus: reset, directed table, then random phases at several bases
    initial begin : stimulus
        t_walk_req rq;
        int ph, k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        //        cmd          index      byte   cluster   sector     entry    status         end
        add_row_x(CMD_UNUSED,  13'h1FFF,  8'hFF, 12'hFFF,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_WRITE,   13'd0,     8'h34, 12'h000,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_WRITE,   13'd1,     8'h12, 12'hABC,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_WRITE,   13'h1FFF,  8'hFF, 12'h000,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row  (CMD_ADVANCE, 13'd0,     8'h00, 12'h000);
        add_row_x(CMD_WRITE,   13'd846,   8'hFF, 12'h000,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_WRITE,   13'd847,   8'h0F, 12'h000,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_ADVANCE, 13'd0,     8'h00, 12'h000,  16'd595,   12'hFFF, STAT_END,      1'b1);
        add_row_x(CMD_ADVANCE, 13'd0,     8'h00, 12'h000,  16'd595,   12'hFFF, STAT_END,      1'b1);
        add_row_x(CMD_UNUSED,  13'h0AAA,  8'h55, 12'h555,  16'd0,     12'h000, STAT_CONTINUE, 1'b1);
        add_row_x(CMD_START,   13'h1555,  8'hAA, 12'hFFF,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_WRITE,   13'd6142,  8'h00, 12'h000,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_WRITE,   13'd6143,  8'h00, 12'h000,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_ADVANCE, 13'd0,     8'h00, 12'h000,  16'd4126,  12'h000, STAT_CORRUPT,  1'b1);
        add_row_x(CMD_START,   13'd0,     8'h00, 12'h001,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_WRITE,   13'd1,     8'h82, 12'h000,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_WRITE,   13'd2,     8'hFF, 12'h000,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_ADVANCE, 13'd0,     8'h00, 12'h000,  16'd32,    12'hFF8, STAT_END,      1'b1);
        // base 0: cluster 0 wraps to the top sector
        add_cfg(16'd0);
        add_row_x(CMD_START,   13'd0,     8'h00, 12'h000,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row  (CMD_ADVANCE, 13'd0,     8'h00, 12'h000);
        add_row_x(CMD_ADVANCE, 13'd0,     8'h00, 12'h000,  16'd563,   12'hFFF, STAT_END,      1'b1);
        add_cfg(16'd61440);
        add_row_x(CMD_START,   13'd0,     8'h00, 12'hFFF,  16'd0,     12'h000, STAT_CONTINUE, 1'b0);
        add_row_x(CMD_ADVANCE, 13'd0,     8'h00, 12'h000,  16'hFFFE,  12'h000, STAT_CORRUPT,  1'b1);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) set_base(dir_rows[i].base);
            else send(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
        end

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_base(16'd1);
                1: set_base(16'd61440);
                2: set_base(16'hFFFF);
                3: set_base(SECTOR_W'($urandom_range(1, 61440)));
                default: set_base(BASE_RESET);
            endcase
            for (k = 0; k < PHASE_REQS; k++) begin
                next_req(rq);
                send(rq, 1'b0, '0);
            end
        end

        // Drain, then a short tail for stray results
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d requests over %0d base settings: %0d advances, %0d end markers,",
                 n_reqs, n_bases, n_adv, n_end);
        $display("%0d corrupt entries; %0d results checked, %0d mismatches.",
                 n_corrupt, n_results, n_bad);
        if (n_bad == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result receiver: random stalls plus one long hold-off to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && n_results >= 700) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 300;
            hold_done     <= 1'b1;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= pick_gap(calm);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results <= n_results + 1;
            if (pending_results.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: result with nothing pending: tdata %h tuser %h",
                             $realtime, m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[15:0]  !== want.data_sector  ||
                    m_axis_tdata[27:16] !== want.next_cluster ||
                    m_axis_tuser[1:0]   !== want.chain_status ||
                    m_axis_tuser[2]     !== want.end_flag) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: mismatch sector %h/%h entry %h/%h status %0d/%0d end %b/%b",
                                 $realtime, want.data_sector, m_axis_tdata[15:0],
                                 want.next_cluster, m_axis_tdata[27:16],
                                 want.chain_status, m_axis_tuser[1:0],
                                 want.end_flag, m_axis_tuser[2]);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
